FILE: rtl/tpa_pkg.sv
// shared constants, codes and control types of the two-region page allocator
package tpa_pkg;

    // fixed field widths
    localparam int ADDR_W    = 40;
    localparam int KPC_W     = 11;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int FREE_W    = 13;
    localparam int CFG_IDX_W = 2;

    // parameter defaults
    localparam int PAGE_BYTES_DEF       = 4096;
    localparam int KERNEL_PAGES_MAX_DEF = 1024;
    localparam int USER_PAGES_MAX_DEF   = 4096;

    // kernel page count after reset
    localparam logic [KPC_W-1:0] KPC_RESET = 11'd256;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_INIT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_PAGES = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISALIGN = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_CFG  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KPC   = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic                latch;
        logic                chk1;
        logic                chk2;
        logic                commit;
        logic                fill;
        logic                pop;
        logic                push;
        logic                finish;
        logic                status_we;
        logic [STATUS_W-1:0] status;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic                ready;
        logic                empty;
        logic                cfg_bad;
        logic                fill_done;
        logic [STATUS_W-1:0] free_code;
    } t_stat;

endpackage

FILE: rtl/tpa_ctrl.sv
// sequencing state machine of the two-region page allocator
module tpa_ctrl
    import tpa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [KIND_W-1:0] i_kind,
    input  t_stat             i_stat,
    output t_cmd              o_cmd,
    output logic              o_busy,
    output logic              o_strobe
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK1,
        S_CHK2,
        S_CHK3,
        S_FILL,
        S_ALLOC,
        S_FREE,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_strobe, n_strobe;

    // next state and command decode
    always_comb begin
        o_cmd    = '0;
        n_state  = r_state;
        n_strobe = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    case (i_kind)
                        KIND_INIT:  n_state = i_stat.ready ? S_FIN : S_CHK1;
                        KIND_ALLOC: n_state = S_ALLOC;
                        KIND_FREE:  n_state = S_FREE;
                        default:    n_state = S_FIN;
                    endcase
                end
            end
            S_CHK1: begin
                o_cmd.chk1 = 1'b1;
                n_state    = S_CHK2;
            end
            S_CHK2: begin
                o_cmd.chk2 = 1'b1;
                n_state    = S_CHK3;
            end
            S_CHK3: begin
                if (i_stat.cfg_bad) begin
                    o_cmd.status_we = 1'b1;
                    o_cmd.status    = ST_BAD_CFG;
                    n_state         = S_FIN;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_FILL;
                end
            end
            S_FILL: begin
                if (i_stat.fill_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.fill = 1'b1;
                end
            end
            S_ALLOC: begin
                if (i_stat.empty) begin
                    o_cmd.status_we = 1'b1;
                    o_cmd.status    = ST_NO_PAGES;
                end else begin
                    o_cmd.pop = 1'b1;
                end
                n_state = S_FIN;
            end
            S_FREE: begin
                o_cmd.status_we = 1'b1;
                o_cmd.status    = i_stat.free_code;
                o_cmd.push      = (i_stat.free_code == ST_OK);
                n_state         = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_strobe     = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

endmodule

FILE: rtl/tpa_datapath.sv
// configuration, region bounds, free counts and page stacks of the allocator
module tpa_datapath
    import tpa_pkg::*;
#(
    parameter int PAGE_BYTES       = PAGE_BYTES_DEF,
    parameter int KERNEL_PAGES_MAX = KERNEL_PAGES_MAX_DEF,
    parameter int USER_PAGES_MAX   = USER_PAGES_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    input  logic                 i_for_kernel,
    input  logic [ADDR_W-1:0]    i_page_address,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    output logic [STATUS_W-1:0]  o_status,
    output logic [ADDR_W-1:0]    o_granted_address,
    output logic [FREE_W-1:0]    o_free_pages
);

    localparam int PG_SH = $clog2(PAGE_BYTES);
    localparam int PN_W  = ADDR_W - PG_SH;
    localparam int KC_W  = $clog2(KERNEL_PAGES_MAX + 1);
    localparam int UC_W  = $clog2(USER_PAGES_MAX + 1);
    localparam int KA_W  = (KERNEL_PAGES_MAX > 1) ? $clog2(KERNEL_PAGES_MAX) : 1;
    localparam int UA_W  = (USER_PAGES_MAX > 1) ? $clog2(USER_PAGES_MAX) : 1;
    localparam int FI_W  = (KC_W > UC_W) ? KC_W : UC_W;
    localparam logic [PN_W:0] KMAX_X = (PN_W + 1)'(KERNEL_PAGES_MAX);
    localparam logic [PN_W:0] UMAX_X = (PN_W + 1)'(USER_PAGES_MAX);

    // configuration registers
    logic [ADDR_W-1:0] r_base, r_limit;
    logic [KPC_W-1:0]  r_kpc;

    // captured request
    logic              r_kern;
    logic [ADDR_W-1:0] r_addr;
    logic [STATUS_W-1:0] r_status;
    logic              r_grant_ok;

    // configuration check scratch
    logic              r_bad;
    logic [PN_W:0]     r_kend;
    logic [PN_W-1:0]   r_udiff;

    // region state
    logic              r_ready;
    logic [PN_W-1:0]   r_kb, r_ke, r_ue;
    logic [KC_W-1:0]   r_kcnt, r_kcap;
    logic [UC_W-1:0]   r_ucnt, r_ucap;

    // fill sweep
    logic [FI_W-1:0]   r_fill_idx;
    logic [PN_W-1:0]   r_kfill_pn, r_ufill_pn;

    // stacks and read data
    logic [PN_W-1:0]   r_kmem [KERNEL_PAGES_MAX];
    logic [PN_W-1:0]   r_umem [USER_PAGES_MAX];
    logic [PN_W-1:0]   r_krd, r_urd;

    logic [PN_W-1:0]   b_pn, l_pn, a_pn, rd_pn;
    logic [KC_W-1:0]   k_top;
    logic [UC_W-1:0]   u_top;
    logic              k_fill_we, u_fill_we;
    logic              k_push, u_push, k_pop, u_pop;
    logic              misalign, out_range, full;

    assign b_pn = r_base[ADDR_W-1:PG_SH];
    assign l_pn = r_limit[ADDR_W-1:PG_SH];
    assign a_pn = r_addr[ADDR_W-1:PG_SH];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_limit <= '0;
            r_kpc   <= KPC_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE:  r_base  <= i_cfg_data;
                CFG_LIMIT: r_limit <= i_cfg_data;
                CFG_KPC:   r_kpc   <= i_cfg_data[KPC_W-1:0];
                default: ;
            endcase
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kern <= i_for_kernel;
            r_addr <= i_page_address;
        end
    end

    // request status and grant flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status   <= ST_OK;
            r_grant_ok <= 1'b0;
        end else if (i_cmd.latch) begin
            r_status   <= ST_OK;
            r_grant_ok <= 1'b0;
        end else begin
            if (i_cmd.status_we) r_status <= i_cmd.status;
            if (i_cmd.pop) r_grant_ok <= 1'b1;
        end
    end

    // configuration check, three steps in page units
    always_ff @(posedge i_clk) begin
        if (i_cmd.chk1) begin
            r_bad  <= (|r_base[PG_SH-1:0]) | (|r_limit[PG_SH-1:0]) | (r_limit <= r_base);
            r_kend <= {1'b0, b_pn} + (PN_W + 1)'(r_kpc);
        end else if (i_cmd.chk2) begin
            r_bad   <= r_bad | (r_kend > {1'b0, l_pn}) | ((PN_W + 1)'(r_kpc) > KMAX_X);
            r_udiff <= l_pn - r_kend[PN_W-1:0];
        end
    end

    // region bounds, capacities and free counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            r_kb    <= '0;
            r_ke    <= '0;
            r_ue    <= '0;
            r_kcap  <= '0;
            r_ucap  <= '0;
            r_kcnt  <= '0;
            r_ucnt  <= '0;
        end else if (i_cmd.commit) begin
            r_ready <= 1'b1;
            r_kb    <= b_pn;
            r_ke    <= r_kend[PN_W-1:0];
            r_ue    <= l_pn;
            r_kcap  <= KC_W'(r_kpc);
            r_ucap  <= UC_W'(r_udiff);
            r_kcnt  <= KC_W'(r_kpc);
            r_ucnt  <= UC_W'(r_udiff);
        end else begin
            if (k_pop) r_kcnt <= k_top;
            if (u_pop) r_ucnt <= u_top;
            if (k_push) r_kcnt <= r_kcnt + 1'b1;
            if (u_push) r_ucnt <= r_ucnt + 1'b1;
        end
    end

    // fill sweep, both stacks side by side in ascending page order
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_fill_idx <= '0;
            r_kfill_pn <= b_pn;
            r_ufill_pn <= r_kend[PN_W-1:0];
        end else if (i_cmd.fill) begin
            r_fill_idx <= r_fill_idx + 1'b1;
            r_kfill_pn <= r_kfill_pn + 1'b1;
            r_ufill_pn <= r_ufill_pn + 1'b1;
        end
    end

    assign k_fill_we = i_cmd.fill && (r_fill_idx < FI_W'(r_kcap));
    assign u_fill_we = i_cmd.fill && (r_fill_idx < FI_W'(r_ucap));
    assign k_push    = i_cmd.push && r_kern;
    assign u_push    = i_cmd.push && !r_kern;
    assign k_pop     = i_cmd.pop && r_kern;
    assign u_pop     = i_cmd.pop && !r_kern;
    assign k_top     = r_kcnt - 1'b1;
    assign u_top     = r_ucnt - 1'b1;

    // kernel stack
    always_ff @(posedge i_clk) begin
        if (k_fill_we) begin
            r_kmem[r_fill_idx[KA_W-1:0]] <= r_kfill_pn;
        end else if (k_push) begin
            r_kmem[r_kcnt[KA_W-1:0]] <= a_pn;
        end
        if (k_pop) r_krd <= r_kmem[k_top[KA_W-1:0]];
    end

    // user stack
    always_ff @(posedge i_clk) begin
        if (u_fill_we) begin
            r_umem[r_fill_idx[UA_W-1:0]] <= r_ufill_pn;
        end else if (u_push) begin
            r_umem[r_ucnt[UA_W-1:0]] <= a_pn;
        end
        if (u_pop) r_urd <= r_umem[u_top[UA_W-1:0]];
    end

    // free checks: alignment, then range, then full stack
    assign misalign  = |r_addr[PG_SH-1:0];
    assign out_range = r_kern ? ((a_pn < r_kb) || (a_pn >= r_ke))
                              : ((a_pn < r_ke) || (a_pn >= r_ue));
    assign full      = r_kern ? (r_kcnt >= r_kcap) : (r_ucnt >= r_ucap);

    always_comb begin
        o_stat.ready     = r_ready;
        o_stat.empty     = r_kern ? (r_kcnt == '0) : (r_ucnt == '0);
        o_stat.cfg_bad   = r_bad | ({1'b0, r_udiff} > UMAX_X);
        o_stat.fill_done = (r_fill_idx >= FI_W'(r_kcap)) && (r_fill_idx >= FI_W'(r_ucap));
        if (misalign)       o_stat.free_code = ST_MISALIGN;
        else if (out_range) o_stat.free_code = ST_RANGE;
        else if (full)      o_stat.free_code = ST_FULL;
        else                o_stat.free_code = ST_OK;
    end

    // result registers
    assign rd_pn = r_kern ? r_krd : r_urd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_status          <= r_status;
            o_granted_address <= r_grant_ok ? {rd_pn, {PG_SH{1'b0}}} : '0;
            o_free_pages      <= r_kern ? FREE_W'(r_kcnt) : FREE_W'(r_ucnt);
        end
    end

endmodule

FILE: rtl/two_region_page_allocator.sv
// top level of the two-region page allocator
//
// A request is taken when i_start is high while o_busy is low: i_kind selects
// init, allocate or free, i_for_kernel picks the kernel or user region and
// i_page_address is the page to free. Each request gives one result, shown for
// exactly one cycle with o_strobe high on o_status, o_granted_address and
// o_free_pages; the receiver cannot stall, so results are never held back.
// o_busy falls in the strobe cycle, so a new request may be taken there.
// Allocate and free pass through one state for the stack pop or push with its
// registered memory read and one to load the result registers. A repeat init
// or an unknown kind goes straight to the result state. A first init runs a
// three-step configuration check and, if it passes, sweeps both stacks side by
// side at one entry per cycle until both are filled.
// Configuration writes use i_cfg_valid, i_cfg_index and i_cfg_data; o_cfg_ready
// is always high and writes are expected only while no request is in flight.
// Synchronous reset clears the controller, the free counts and the region
// bounds; the block is then not initialized and reset configuration is loaded.
module two_region_page_allocator
    import tpa_pkg::*;
#(
    parameter int PAGE_BYTES       = PAGE_BYTES_DEF,
    parameter int KERNEL_PAGES_MAX = KERNEL_PAGES_MAX_DEF,
    parameter int USER_PAGES_MAX   = USER_PAGES_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic                 i_for_kernel,
    input  logic [ADDR_W-1:0]    i_page_address,
    output logic                 o_strobe,
    output logic [STATUS_W-1:0]  o_status,
    output logic [ADDR_W-1:0]    o_granted_address,
    output logic [FREE_W-1:0]    o_free_pages,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    // controller
    tpa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_kind   (i_kind),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (o_busy),
        .o_strobe (o_strobe)
    );

    // datapath with both stacks
    tpa_datapath #(
        .PAGE_BYTES       (PAGE_BYTES),
        .KERNEL_PAGES_MAX (KERNEL_PAGES_MAX),
        .USER_PAGES_MAX   (USER_PAGES_MAX)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_for_kernel      (i_for_kernel),
        .i_page_address    (i_page_address),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_status          (o_status),
        .o_granted_address (o_granted_address),
        .o_free_pages      (o_free_pages)
    );

endmodule

FILE: rtl/tpa_checker.sv
// port-level checks of the two-region page allocator and their bind
module tpa_checker
    import tpa_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_start,
    input logic                o_busy,
    input logic                o_strobe,
    input logic [STATUS_W-1:0] o_status,
    input logic [ADDR_W-1:0]   o_granted_address
);

    // a taken request always makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("request taken but block not busy");

    // a result closes its request, so the block is free again
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !o_busy)
        else $error("result shown while still busy");

    // one result per request, never back to back
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("results in consecutive cycles");

    // status stays within the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_status <= ST_FULL))
        else $error("undefined status code");

    // no page is granted with an error
    a_err_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status != ST_OK)) |-> (o_granted_address == '0))
        else $error("page granted with an error status");

endmodule

bind two_region_page_allocator tpa_checker u_tpa_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_start           (i_start),
    .o_busy            (o_busy),
    .o_strobe          (o_strobe),
    .o_status          (o_status),
    .o_granted_address (o_granted_address)
);

FILE: sim/two_region_page_allocator_tb.sv
`timescale 1ns / 100ps
// self-checking testbench of the two-region page allocator
module two_region_page_allocator_tb;
    import tpa_pkg::*;

    // codes with no name in the package
    localparam logic [KIND_W-1:0]    KIND_UNKNOWN = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;

    localparam longint unsigned PAGE  = 64'(PAGE_BYTES_DEF);
    localparam longint unsigned K_MAX = 64'(KERNEL_PAGES_MAX_DEF);
    localparam longint unsigned U_MAX = 64'(USER_PAGES_MAX_DEF);
    localparam int PN_W        = ADDR_W - $clog2(PAGE_BYTES_DEF);
    localparam int DRAIN_LIMIT = 20000;

    localparam logic [ADDR_W-1:0] PAGE_ADDR = ADDR_W'(PAGE_BYTES_DEF);
    localparam logic [ADDR_W-1:0] TOP_PAGE  = 40'hFF_FFFF_F000;
    localparam logic [ADDR_W-1:0] ALL_ONES  = 40'hFF_FFFF_FFFF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   granted;
        logic [FREE_W-1:0]   free_pages;
    } t_page_reply;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_start        = 1'b0;
    logic [KIND_W-1:0]    i_kind         = KIND_INIT;
    logic                 i_for_kernel   = 1'b0;
    logic [ADDR_W-1:0]    i_page_address = '0;
    logic                 i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = CFG_BASE;
    logic [ADDR_W-1:0]    i_cfg_data     = '0;
    logic                 o_busy;
    logic                 o_strobe;
    logic [STATUS_W-1:0]  o_status;
    logic [ADDR_W-1:0]    o_granted_address;
    logic [FREE_W-1:0]    o_free_pages;
    logic                 o_cfg_ready;

    int          error_count     = 0;
    int          sender_idle_pct = 0;
    t_page_reply pending_replies[$];

    // shadow registers and allocator state
    logic [ADDR_W-1:0] base_reg  = '0;
    logic [ADDR_W-1:0] limit_reg = '0;
    logic [KPC_W-1:0]  kpc_reg   = KPC_RESET;
    bit                pool_ready = 1'b0;
    logic [ADDR_W-1:0] kern_lo = '0;
    logic [ADDR_W-1:0] kern_hi = '0;
    logic [ADDR_W-1:0] user_lo = '0;
    logic [ADDR_W-1:0] user_hi = '0;
    logic [PN_W-1:0]   kern_stack [KERNEL_PAGES_MAX_DEF];
    logic [PN_W-1:0]   user_stack [USER_PAGES_MAX_DEF];
    longint unsigned   kern_free = 0;
    longint unsigned   user_free = 0;

    two_region_page_allocator DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_kind            (i_kind),
        .i_for_kernel      (i_for_kernel),
        .i_page_address    (i_page_address),
        .o_strobe          (o_strobe),
        .o_status          (o_status),
        .o_granted_address (o_granted_address),
        .o_free_pages      (o_free_pages),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // expected reply of one request, updates the allocator state
    function automatic t_page_reply predict_page_op(input logic [KIND_W-1:0] kind,
                                                    input logic for_kernel,
                                                    input logic [ADDR_W-1:0] addr);
        t_page_reply     r;
        longint unsigned lo, hi, cnt, depth, cap, b, l, kp, kend, up, i, a;
        r     = '0;
        lo    = 64'(for_kernel ? kern_lo : user_lo);
        hi    = 64'(for_kernel ? kern_hi : user_hi);
        cnt   = for_kernel ? kern_free : user_free;
        depth = for_kernel ? K_MAX : U_MAX;
        a     = 64'(addr);
        case (kind)
            KIND_INIT: begin
                // repeat init is ignored, bad settings leave the pools untouched
                if (!pool_ready) begin
                    b  = 64'(base_reg);
                    l  = 64'(limit_reg);
                    kp = 64'(kpc_reg);
                    if (b % PAGE != 0 || l % PAGE != 0 || l <= b || b + kp * PAGE > l) begin
                        r.status = ST_BAD_CFG;
                    end else begin
                        kend = b + kp * PAGE;
                        up   = (l - kend) / PAGE;
                        if (kp > K_MAX || up > U_MAX) begin
                            r.status = ST_BAD_CFG;
                        end else begin
                            kern_lo = ADDR_W'(b);
                            kern_hi = ADDR_W'(kend);
                            user_lo = ADDR_W'(kend);
                            user_hi = ADDR_W'(l);
                            for (i = 0; i < kp; i++) kern_stack[i] = PN_W'(b / PAGE + i);
                            for (i = 0; i < up; i++) user_stack[i] = PN_W'(kend / PAGE + i);
                            kern_free  = kp;
                            user_free  = up;
                            pool_ready = 1'b1;
                        end
                    end
                end
            end
            KIND_ALLOC: begin
                // pop the top page
                if (cnt == 0 || cnt > depth) begin
                    r.status = ST_NO_PAGES;
                end else begin
                    cnt--;
                    r.granted = ADDR_W'((for_kernel ? 64'(kern_stack[cnt])
                                                    : 64'(user_stack[cnt])) * PAGE);
                    if (for_kernel) kern_free = cnt;
                    else user_free = cnt;
                end
            end
            KIND_FREE: begin
                // alignment, then range, then full stack
                cap = (hi - lo) / PAGE;
                if (a % PAGE != 0) begin
                    r.status = ST_MISALIGN;
                end else if (a < lo || a >= hi) begin
                    r.status = ST_RANGE;
                end else if (cnt >= cap || cnt >= depth) begin
                    r.status = ST_FULL;
                end else begin
                    if (for_kernel) kern_stack[cnt] = PN_W'(a / PAGE);
                    else user_stack[cnt] = PN_W'(a / PAGE);
                    cnt++;
                    if (for_kernel) kern_free = cnt;
                    else user_free = cnt;
                end
            end
            default: ;
        endcase
        r.free_pages = FREE_W'(for_kernel ? kern_free : user_free);
        return r;
    endfunction

    // one configuration write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        case (idx)
            CFG_BASE:  base_reg  = data;
            CFG_LIMIT: limit_reg = data;
            CFG_KPC:   kpc_reg   = data[KPC_W-1:0];
            default:   ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // one request, with an optional gap in front
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic for_kernel,
                                input logic [ADDR_W-1:0] addr);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_start        <= 1'b1;
        i_kind         <= kind;
        i_for_kernel   <= for_kernel;
        i_page_address <= addr;
        @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
        @(posedge i_clk);
        pending_replies.push_back(predict_page_op(kind, for_kernel, addr));
    endtask

    // stop sending and wait for every outstanding reply
    task automatic drain_replies();
        int waited;
        waited = 0;
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_replies.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_replies.size() != 0) begin
            $error("%0d replies never arrived", pending_replies.size());
            error_count++;
            pending_replies.delete();
        end
    endtask

    // load all three registers and try an init
    task automatic config_and_init(input logic [ADDR_W-1:0] base,
                                   input logic [ADDR_W-1:0] limit,
                                   input logic [ADDR_W-1:0] kpc_data);
        write_reg(CFG_BASE, base);
        write_reg(CFG_LIMIT, limit);
        write_reg(CFG_KPC, kpc_data);
        send_request(KIND_INIT, 1'($urandom_range(1)), ADDR_W'({$urandom(), $urandom()}));
        drain_replies();
    endtask

    // allocate, free and an unknown kind before any init
    task automatic test_before_init();
        send_request(KIND_ALLOC, 1'b1, '0);
        send_request(KIND_ALLOC, 1'b0, ALL_ONES);
        send_request(KIND_FREE, 1'b1, '0);
        send_request(KIND_FREE, 1'b0, ALL_ONES);
        send_request(KIND_FREE, 1'b1, TOP_PAGE);
        send_request(KIND_UNKNOWN, 1'b0, TOP_PAGE);
        drain_replies();
    endtask

    // every kind of bad configuration, init must stay retryable
    task automatic test_bad_config();
        send_request(KIND_INIT, 1'b0, '0);
        drain_replies();
        write_reg(CFG_SPARE, ADDR_W'({$urandom(), $urandom()}));
        config_and_init(TOP_PAGE, 40'h0, 40'd0);
        config_and_init(40'h1000, 40'h1000, 40'd0);
        config_and_init(40'h800, 40'h1_0000, 40'd1);
        config_and_init(40'h0, ALL_ONES, 40'd0);
        config_and_init(40'h0, 40'h1_0000, 40'd17);
        config_and_init(40'h0, 40'h7D_0000, 40'd1025);
        config_and_init(40'hFF_FFFF_0000, TOP_PAGE, 40'hFF_FFFF_F7FF);
        config_and_init(40'h0, 40'h100_1000, 40'd0);
    endtask

    // the one good init with small random regions, then a repeat
    task automatic test_first_init();
        int unsigned       kp, up;
        logic [ADDR_W-1:0] base, kpc_data;
        kp       = $urandom_range(1, 10);
        up       = $urandom_range(1, 14);
        base     = ADDR_W'($urandom_range(28'hFFF_FF00)) * PAGE_ADDR;
        kpc_data = ADDR_W'({$urandom(), $urandom()});
        kpc_data[KPC_W-1:0] = KPC_W'(kp);
        write_reg(CFG_BASE, base);
        write_reg(CFG_LIMIT, base + ADDR_W'(kp + up) * PAGE_ADDR);
        write_reg(CFG_KPC, kpc_data);
        send_request(KIND_INIT, 1'b1, '0);
        send_request(KIND_INIT, 1'b0, ALL_ONES);
        drain_replies();
    endtask

    // full stacks, highest page first, region boundaries
    task automatic test_region_edges();
        send_request(KIND_FREE, 1'b1, kern_lo);
        send_request(KIND_ALLOC, 1'b1, '0);
        send_request(KIND_FREE, 1'b1, kern_hi - PAGE_ADDR);
        send_request(KIND_FREE, 1'b0, user_hi);
        send_request(KIND_FREE, 1'b0, user_lo - PAGE_ADDR);
        send_request(KIND_FREE, 1'b1, ALL_ONES);
        send_request(KIND_FREE, 1'b0, TOP_PAGE);
        send_request(KIND_ALLOC, 1'b0, ALL_ONES);
        send_request(KIND_UNKNOWN, 1'b1, '0);
        drain_replies();
    endtask

    // new settings after init must not change anything
    task automatic test_ignored_config(input bit extremes);
        if (extremes) begin
            write_reg(CFG_BASE, '0);
            write_reg(CFG_LIMIT, TOP_PAGE);
            write_reg(CFG_KPC, '0);
        end else begin
            write_reg(CFG_BASE, ADDR_W'({$urandom(), $urandom()}));
            write_reg(CFG_LIMIT, ADDR_W'({$urandom(), $urandom()}));
            write_reg(CFG_KPC, ADDR_W'({$urandom(), $urandom()}));
        end
        send_request(KIND_INIT, 1'($urandom_range(1)), '0);
        drain_replies();
    endtask

    // mostly well-formed alloc and free traffic with some noise
    task automatic test_random_traffic(input int n_items, input int idle_pct);
        int                n, pick;
        logic              fk;
        logic [ADDR_W-1:0] lo, hi, other_lo, addr;
        int unsigned       pages, other_pages;
        sender_idle_pct = idle_pct;
        for (n = 0; n < n_items; n++) begin
            fk          = 1'($urandom_range(1));
            lo          = fk ? kern_lo : user_lo;
            hi          = fk ? kern_hi : user_hi;
            other_lo    = fk ? user_lo : kern_lo;
            pages       = 32'((hi - lo) / PAGE_ADDR);
            other_pages = fk ? 32'((user_hi - user_lo) / PAGE_ADDR)
                             : 32'((kern_hi - kern_lo) / PAGE_ADDR);
            addr        = ADDR_W'({$urandom(), $urandom()});
            pick        = $urandom_range(99);
            if (pick < 40) begin
                send_request(KIND_ALLOC, fk, addr);
            end else if (pick < 80) begin
                send_request(KIND_FREE, fk,
                             lo + ADDR_W'($urandom_range(pages - 1)) * PAGE_ADDR);
            end else if (pick < 87) begin
                // misaligned page
                if (addr % PAGE_ADDR == '0) addr[0] = 1'b1;
                send_request(KIND_FREE, fk, addr);
            end else if (pick < 94) begin
                // aligned but outside the region
                case ($urandom_range(2))
                    0:       addr = addr - addr % PAGE_ADDR;
                    1:       addr = ($urandom_range(1) != 0) ? hi : lo - PAGE_ADDR;
                    default: addr = other_lo
                                    + ADDR_W'($urandom_range(other_pages - 1)) * PAGE_ADDR;
                endcase
                send_request(KIND_FREE, fk, addr);
            end else if (pick < 97) begin
                send_request(KIND_UNKNOWN, fk, addr);
            end else begin
                send_request(KIND_INIT, fk, addr);
            end
        end
        drain_replies();
    endtask

    // compare each reply with the oldest expectation
    always @(posedge i_clk) begin
        t_page_reply want;
        if (i_rst_n && o_strobe) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected reply, status %0d", o_status);
                error_count++;
            end else begin
                want = pending_replies.pop_front();
                if (o_status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_granted_address !== want.granted) begin
                    $error("granted_address expected %h got %h", want.granted,
                           o_granted_address);
                    error_count++;
                end
                if (o_free_pages !== want.free_pages) begin
                    $error("free_pages expected %0d got %0d", want.free_pages, o_free_pages);
                    error_count++;
                end
            end
        end
    end

    // test sequence
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        sender_idle_pct = 12;
        test_before_init();
        test_bad_config();
        test_first_init();
        test_region_edges();
        test_random_traffic(375, 12);
        test_ignored_config(1'b1);
        test_random_traffic(375, 45);
        test_ignored_config(1'b0);
        test_random_traffic(375, 0);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
rtl/tpa_pkg.sv
rtl/tpa_ctrl.sv
rtl/tpa_datapath.sv
rtl/two_region_page_allocator.sv
rtl/tpa_checker.sv
sim/two_region_page_allocator_tb.sv
